>>> rtl/core/tia_pkg.sv
// tia_pkg: shared types and constants of the translated index allocator
// no dependencies; used by tia_ctrl and translated_index_allocator
`default_nettype none

package tia_pkg;

    // fixed field widths
    localparam int LOCAL_W = 10;
    localparam int OUT_W   = 9;
    localparam int CAP_W   = 9;

    // apb port shape
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, decoded from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET  = 9'd256;
    localparam logic [OUT_W-1:0] UNASSIGNED = 9'h1FF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_DONE
    } t_state;

    // write strobes of the two stores
    typedef struct packed {
        logic map_we;
        logic slot_we;
    } t_mem_ctl;

endpackage

`default_nettype wire

>>> rtl/core/tia_ram.sv
// tia_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/tia_ctrl.sv
// tia_ctrl: sequencer of the allocator (clearing pass, map lookup, slot scan, result)
// depends on tia_pkg; drives the ports of the map and slot rams
`default_nettype none

module tia_ctrl #(
    parameter int SLOTS         = 256,
    parameter int LOCAL_ENTRIES = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [tia_pkg::LOCAL_W-1:0]         i_local_index,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [tia_pkg::OUT_W-1:0]           o_xlat_index,
    input  wire logic [$clog2(SLOTS):0]              i_eff_cap,
    output tia_pkg::t_mem_ctl                        o_mem,
    output logic      [$clog2(LOCAL_ENTRIES)-1:0]    o_map_raddr,
    output logic      [$clog2(LOCAL_ENTRIES)-1:0]    o_map_waddr,
    output logic      [$clog2(SLOTS):0]              o_map_wdata,
    input  wire logic [$clog2(SLOTS):0]              i_map_rdata,
    output logic      [$clog2(SLOTS)-1:0]            o_slot_raddr,
    output logic      [$clog2(SLOTS)-1:0]            o_slot_waddr,
    output logic                                     o_slot_wdata,
    input  wire logic                                i_slot_used
);

    localparam int SW    = $clog2(SLOTS);
    localparam int EW    = SW + 1;
    localparam int LAW   = $clog2(LOCAL_ENTRIES);
    localparam int CLR_N = (LOCAL_ENTRIES > SLOTS) ? LOCAL_ENTRIES : SLOTS;
    localparam int CLW   = $clog2(CLR_N);
    localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_N - 1);

    tia_pkg::t_state r_state, n_state;

    logic [CLW-1:0]                r_clr;
    logic [LAW-1:0]                r_laddr;
    logic                          r_oor;
    logic [SW-1:0]                 r_cursor;
    logic [SW-1:0]                 r_start;
    logic [SW-1:0]                 r_chk;
    logic [EW-1:0]                 r_left;
    logic [tia_pkg::OUT_W-1:0]     r_res;
    logic                          r_out_valid;
    logic [tia_pkg::OUT_W-1:0]     r_out_data;

    logic [31:0]    w_local_ext;
    logic [LAW-1:0] w_laddr;
    logic           w_oor;
    logic [SW-1:0]  w_start;
    logic [EW-1:0]  w_inc;
    logic [SW-1:0]  w_nxt;
    logic           w_hit;
    logic [31:0]    w_hit_ext;
    logic [31:0]    w_chk_ext;
    logic [31:0]    w_clr_ext;
    logic           w_load;

    assign w_local_ext = 32'(i_local_index);
    assign w_laddr     = w_local_ext[LAW-1:0];
    assign w_oor       = (w_local_ext >= 32'(LOCAL_ENTRIES));

    // scan start, slot 0 when the cursor lies beyond a lowered capacity
    assign w_start = ({1'b0, r_cursor} < i_eff_cap) ? r_cursor : '0;

    // ring successor of the slot being checked
    assign w_inc = {1'b0, r_chk} + EW'(1);
    assign w_nxt = (w_inc >= i_eff_cap) ? '0 : w_inc[SW-1:0];

    assign w_hit     = i_map_rdata[SW];
    assign w_hit_ext = 32'(i_map_rdata[SW-1:0]);
    assign w_chk_ext = 32'(r_chk);
    assign w_clr_ext = 32'(r_clr);

    assign w_load = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tia_pkg::ST_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = tia_pkg::ST_IDLE;
                end
            end
            tia_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tia_pkg::ST_LOOKUP;
                end
            end
            tia_pkg::ST_LOOKUP: begin
                if (r_oor || w_hit) begin
                    n_state = tia_pkg::ST_DONE;
                end else begin
                    n_state = tia_pkg::ST_SCAN;
                end
            end
            tia_pkg::ST_SCAN: begin
                if (!i_slot_used || (r_left == '0)) begin
                    n_state = tia_pkg::ST_DONE;
                end
            end
            tia_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = tia_pkg::ST_IDLE;
                end
            end
            default: n_state = tia_pkg::ST_CLEAR;
        endcase
    end

    // outputs to the rams and the input handshake
    always_comb begin
        o_in_ready     = 1'b0;
        o_mem.map_we   = 1'b0;
        o_mem.slot_we  = 1'b0;
        o_map_raddr    = w_laddr;
        o_map_waddr    = r_laddr;
        o_map_wdata    = {1'b1, r_chk};
        o_slot_raddr   = w_start;
        o_slot_waddr   = r_chk;
        o_slot_wdata   = 1'b1;
        unique case (r_state)
            tia_pkg::ST_CLEAR: begin
                o_mem.map_we  = (w_clr_ext < 32'(LOCAL_ENTRIES));
                o_mem.slot_we = (w_clr_ext < 32'(SLOTS));
                o_map_waddr   = w_clr_ext[LAW-1:0];
                o_map_wdata   = '0;
                o_slot_waddr  = w_clr_ext[SW-1:0];
                o_slot_wdata  = 1'b0;
            end
            tia_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            tia_pkg::ST_LOOKUP: begin
                o_slot_raddr = w_start;
            end
            tia_pkg::ST_SCAN: begin
                o_slot_raddr  = w_nxt;
                o_mem.map_we  = !i_slot_used;
                o_mem.slot_we = !i_slot_used;
            end
            tia_pkg::ST_DONE: begin
                o_in_ready = 1'b0;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tia_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            case (r_state)
                tia_pkg::ST_CLEAR: begin
                    r_clr <= r_clr + CLW'(1);
                end
                tia_pkg::ST_IDLE: begin
                    if (i_in_valid) begin
                        r_laddr <= w_laddr;
                        r_oor   <= w_oor;
                    end
                end
                tia_pkg::ST_LOOKUP: begin
                    r_start <= w_start;
                    r_chk   <= w_start;
                    r_left  <= i_eff_cap - EW'(1);
                    if (r_oor) begin
                        r_res <= tia_pkg::UNASSIGNED;
                    end else begin
                        r_res <= w_hit_ext[tia_pkg::OUT_W-1:0];
                    end
                end
                tia_pkg::ST_SCAN: begin
                    if (!i_slot_used) begin
                        r_res    <= w_chk_ext[tia_pkg::OUT_W-1:0];
                        r_cursor <= w_nxt;
                    end else if (r_left == '0) begin
                        r_res    <= tia_pkg::UNASSIGNED;
                        r_cursor <= r_start;
                    end else begin
                        r_chk  <= w_nxt;
                        r_left <= r_left - EW'(1);
                    end
                end
                default: begin
                end
            endcase

            if ((r_state == tia_pkg::ST_DONE) && w_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_res;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_xlat_index = r_out_data;

endmodule

`default_nettype wire

>>> rtl/core/translated_index_allocator.sv
// translated_index_allocator: next-fit allocator of translated slot indexes
// depends on tia_pkg, tia_ram and tia_ctrl
// result path: accept, then LOOKUP, DONE and the result register on a hit or out-of-range index; a
// new assignment adds a ring scan of k slots, k = 1 to capacity; input is ready again once the result loads
// throughput: one word at a time, one slot per cycle in the scan; a held result stalls it
// reset: sync, active low; then a clearing pass over max(LOCAL_ENTRIES, SLOTS) addresses
`default_nettype none

module translated_index_allocator #(
    parameter int SLOTS         = 256,
    parameter int LOCAL_ENTRIES = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [tia_pkg::LOCAL_W-1:0]       i_local_index,

    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [tia_pkg::OUT_W-1:0]       o_xlat_index,

    // apb configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tia_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [tia_pkg::PDATA_W-1:0]       pwdata,
    output logic      [tia_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready
);

    localparam int SW  = $clog2(SLOTS);
    localparam int EW  = SW + 1;
    localparam int LAW = $clog2(LOCAL_ENTRIES);

    // capacity register
    logic [tia_pkg::CAP_W-1:0] r_capacity;
    logic                      w_reg_hit;
    logic [31:0]               w_cap_ext;
    logic [EW-1:0]             w_eff_cap;

    // ram connections
    tia_pkg::t_mem_ctl w_mem;
    logic [LAW-1:0]    w_map_raddr;
    logic [LAW-1:0]    w_map_waddr;
    logic [EW-1:0]     w_map_wdata;
    logic [EW-1:0]     w_map_rdata;
    logic [SW-1:0]     w_slot_raddr;
    logic [SW-1:0]     w_slot_waddr;
    logic              w_slot_wdata;
    logic              w_slot_rdata;
    logic [tia_pkg::OUT_W-1:0] w_result;

    // only paddr[2] selects a register; one register at byte address 0
    assign w_reg_hit = (paddr[2] == tia_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= tia_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && w_reg_hit) begin
            r_capacity <= pwdata[tia_pkg::CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = w_reg_hit ? tia_pkg::PDATA_W'(r_capacity) : '0;

    // effective capacity: zero counts as one, values above SLOTS clip to SLOTS
    assign w_cap_ext = 32'(r_capacity);
    always_comb begin
        if (r_capacity == '0) begin
            w_eff_cap = EW'(1);
        end else if (w_cap_ext > 32'(SLOTS)) begin
            w_eff_cap = EW'(SLOTS);
        end else begin
            w_eff_cap = w_cap_ext[EW-1:0];
        end
    end

    // local to translated map: msb marks an assigned entry, low bits hold the slot
    tia_ram #(
        .WIDTH (EW),
        .DEPTH (LOCAL_ENTRIES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

    // slot table: one occupied flag per slot, the owner itself is never read back
    tia_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    // sequencer: clearing pass, lookup, one-slot-per-cycle ring scan, result register
    tia_ctrl #(
        .SLOTS         (SLOTS),
        .LOCAL_ENTRIES (LOCAL_ENTRIES)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_local_index      (i_local_index),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_xlat_index       (w_result),
        .i_eff_cap          (w_eff_cap),
        .o_mem              (w_mem),
        .o_map_raddr        (w_map_raddr),
        .o_map_waddr        (w_map_waddr),
        .o_map_wdata        (w_map_wdata),
        .i_map_rdata        (w_map_rdata),
        .o_slot_raddr       (w_slot_raddr),
        .o_slot_waddr       (w_slot_waddr),
        .o_slot_wdata       (w_slot_wdata),
        .i_slot_used        (w_slot_rdata)
    );

    // all ones reads as -1 on the signed port
    assign o_xlat_index = signed'(w_result);

endmodule

`default_nettype wire
